### sv/lfd_pkg.sv
// link frame deframer package: beat types, header layout and code constants
// no dependencies; imported by every module of the deframer
package lfd_pkg;

  localparam int HEADER_BYTES = 12;

  localparam logic [3:0] POS_VERSION   = 4'd4;
  localparam logic [3:0] POS_FLAGS     = 4'd5;
  localparam logic [3:0] POS_LENGTH_LO = 4'd6;
  localparam logic [3:0] POS_LENGTH_HI = 4'd7;
  localparam logic [3:0] POS_ROUTE     = 4'd8;
  localparam logic [3:0] POS_LAST      = 4'(HEADER_BYTES - 1);

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  localparam logic [2:0] ERR_MAGIC   = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_FLAGS   = 3'd2;
  localparam logic [2:0] ERR_EMPTY   = 3'd3;
  localparam logic [2:0] ERR_LONG    = 3'd4;

  localparam logic REG_VERSION     = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  localparam logic [7:0] VERSION_RESET     = 8'd1;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] route;
    logic        last_byte;
    logic [2:0]  error_code;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] max_payload;
  } cfg_t;

  // magic "RBU1"
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h52;
      2'd1:    b = 8'h42;
      2'd2:    b = 8'h55;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

### sv/link_frame_deframer.sv
// Link frame deframer. Takes one received byte per beat, parses the 12-byte
// header (magic "RBU1", version, zero flags, 16-bit little-endian length,
// 32-bit little-endian route) and forwards each payload byte as it arrives,
// tagged with the route and flagged on the frame's last byte. A bad header
// gives one error beat on its last byte and the block then drops bytes until
// a clear request. One beat is accepted every cycle while byte_stall is low;
// an input beat goes through the input register, the single parse stage and
// the result register. Registers are written over apb.
// depends on lfd_pkg, lfd_regs and lfd_parser
module link_frame_deframer
  import lfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  in_beat_t    byte_beat,
  output logic        frame_valid,
  input  logic        frame_stall,
  output out_beat_t   frame_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  logic      s1_valid;
  in_beat_t  s1_item;
  logic      advance;
  logic      res_valid;
  out_beat_t res;

  lfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the parse stage moves whenever the result register is free or draining
  assign advance    = s1_valid && (!frame_valid || !frame_stall);
  assign byte_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_item <= byte_beat;
    end
  end

  lfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= res_valid;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      frame_beat <= res;
    end
  end

endmodule

### sv/lfd_regs.sv
// configuration registers of the deframer behind an apb-style port
// depends on lfd_pkg for the register indexes and reset values
module lfd_regs
  import lfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= VERSION_RESET;
      cfg.max_payload      <= MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_VERSION:     cfg.expected_version <= pwdata[7:0];
        REG_MAX_PAYLOAD: cfg.max_payload      <= pwdata[15:0];
        default:         cfg.max_payload      <= cfg.max_payload;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VERSION:     prdata = {24'd0, cfg.expected_version};
      REG_MAX_PAYLOAD: prdata = {16'd0, cfg.max_payload};
      default:         prdata = '0;
    endcase
  end

endmodule

### sv/lfd_parser.sv
// header parser and payload tagger: holds the frame state and forms at most one
// result per processed beat; depends on lfd_pkg
module lfd_parser
  import lfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_beat_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_beat_t res
);

  logic [3:0]  header_pos, header_pos_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] route_word, route_word_next;
  logic [2:0]  pending_error, pending_error_next;
  logic        error_seen, error_seen_next;
  logic        halted, halted_next;

  logic        byte_err;
  logic [2:0]  byte_code;
  logic        len_err;
  logic [2:0]  len_code;
  logic        seen_final;
  logic [2:0]  code_final;

  // per-byte header checks
  always_comb begin
    byte_err  = 1'b0;
    byte_code = ERR_MAGIC;
    if (header_pos inside {[4'd0:4'd3]}) begin
      byte_err  = (item.in_byte != magic_byte(header_pos[1:0]));
      byte_code = ERR_MAGIC;
    end else if (header_pos == POS_VERSION) begin
      byte_err  = (item.in_byte != cfg.expected_version);
      byte_code = ERR_VERSION;
    end else if (header_pos == POS_FLAGS) begin
      byte_err  = (item.in_byte != 8'd0);
      byte_code = ERR_FLAGS;
    end
  end

  // length checks on the header's last byte
  always_comb begin
    len_err  = (declared_length == 16'd0) || (declared_length > cfg.max_payload);
    len_code = (declared_length == 16'd0) ? ERR_EMPTY : ERR_LONG;
  end

  assign seen_final = error_seen || len_err;
  assign code_final = error_seen ? pending_error : len_code;

  always_comb begin
    header_pos_next      = header_pos;
    declared_length_next = declared_length;
    bytes_left_next      = bytes_left;
    route_word_next      = route_word;
    pending_error_next   = pending_error;
    error_seen_next      = error_seen;
    halted_next          = halted;
    res_valid            = 1'b0;
    res                  = '0;
    if (step) begin
      if (item.req_type == REQ_CLEAR) begin
        header_pos_next      = '0;
        declared_length_next = '0;
        bytes_left_next      = '0;
        route_word_next      = '0;
        pending_error_next   = '0;
        error_seen_next      = 1'b0;
        halted_next          = 1'b0;
      end else if (!halted) begin
        if (bytes_left != 16'd0) begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = item.in_byte;
          res.route        = route_word;
          res.last_byte    = (bytes_left == 16'd1);
          bytes_left_next  = bytes_left - 16'd1;
        end else begin
          if (header_pos == POS_LENGTH_LO) begin
            declared_length_next = {declared_length[15:8], item.in_byte};
          end else if (header_pos == POS_LENGTH_HI) begin
            declared_length_next = {item.in_byte, declared_length[7:0]};
          end else if (header_pos >= POS_ROUTE) begin
            case (header_pos[1:0])
              2'd0:    route_word_next[7:0]   = item.in_byte;
              2'd1:    route_word_next[15:8]  = item.in_byte;
              2'd2:    route_word_next[23:16] = item.in_byte;
              default: route_word_next[31:24] = item.in_byte;
            endcase
          end
          if (byte_err && !error_seen) begin
            error_seen_next    = 1'b1;
            pending_error_next = byte_code;
          end
          if (header_pos != POS_LAST) begin
            header_pos_next = header_pos + 4'd1;
          end else begin
            header_pos_next    = '0;
            error_seen_next    = seen_final;
            pending_error_next = code_final;
            if (seen_final) begin
              halted_next    = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = code_final;
            end else begin
              bytes_left_next = declared_length;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos      <= '0;
      declared_length <= '0;
      bytes_left      <= '0;
      route_word      <= '0;
      pending_error   <= '0;
      error_seen      <= 1'b0;
      halted          <= 1'b0;
    end else begin
      header_pos      <= header_pos_next;
      declared_length <= declared_length_next;
      bytes_left      <= bytes_left_next;
      route_word      <= route_word_next;
      pending_error   <= pending_error_next;
      error_seen      <= error_seen_next;
      halted          <= halted_next;
    end
  end

  // a halted parser only leaves that state on a clear request
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    halted && !(step && item.req_type == REQ_CLEAR) |=> halted)
    else $error("parser left halt without a clear");

  // error reports come only from the last header byte
  a_err_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_ERROR |-> header_pos == POS_LAST && bytes_left == 16'd0)
    else $error("error report away from header end");

  // payload phase never overlaps a partly parsed header or a halt
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 16'd0 |-> header_pos == 4'd0 && !halted && !error_seen)
    else $error("payload phase with stale header state");

endmodule
